@@ hw/rtl/utf8d_pkg.sv @@
// shared widths and byte-class constants for the utf-8 decoder
`default_nettype none
package utf8d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  // byte classes, tested as (byte & mask) == pattern
  localparam logic [ByteW-1:0] AsciiMax  = 8'h7F;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;

  // payload masks of lead and continuation bytes
  localparam logic [ByteW-1:0] ContBits  = 8'h3F;
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Bits = 8'h07;

  // continuation bytes still expected after each lead
  localparam logic [PendW-1:0] PendNone  = 2'd0;
  localparam logic [PendW-1:0] PendOne   = 2'd1;
  localparam logic [PendW-1:0] PendTwo   = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

endpackage
`default_nettype wire

@@ hw/rtl/utf8_to_codepoint_decoder.sv @@
// utf-8 byte stream to code point decoder, one byte word per cycle unless stalled
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_ready_o | data_byte_i, end_of_string_i
//  out     | source    | out_valid_o/out_ready_i | code_point_o, ends_string_o
//
// one word is taken every cycle while in_ready_o is high; a word that completes a
// code point passes the input register, then is decoded into the result register
// the decode step is a handful of masks, compares and a six-bit shift
// reset (rst_ni low, asynchronous) empties both registers and clears the
// pending count and the gathered bits
// while the result register is stalled the input register holds one word, so
// at most two words are in flight before in_ready_o drops
`default_nettype none
module utf8_to_codepoint_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [utf8d_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                        end_of_string_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [utf8d_pkg::CpW-1:0]        code_point_o,
  output logic                             ends_string_o
);
  import utf8d_pkg::*;

  // input register
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  // decoder state
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   gath_q, gath_d;

  // result register
  logic           out_valid_q;
  logic [CpW-1:0] out_cp_q;
  logic           out_last_q;

  logic           out_free;
  logic           s1_adv;
  logic           emit;
  logic [CpW-1:0] emit_cp;
  logic [CpW-1:0] shifted;

  // result register can load when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // six fresh bits from a continuation byte, old bits above
  assign shifted = {gath_q[CpW-7:0], s1_byte_q[5:0] & ContBits[5:0]};

  always_comb begin
    pend_d  = pend_q;
    gath_d  = gath_q;
    emit    = 1'b0;
    emit_cp = '0;
    if (s1_adv) begin
      if (pend_q == PendNone) begin
        if (s1_byte_q <= AsciiMax) begin
          emit    = 1'b1;
          emit_cp = {{(CpW-ByteW){1'b0}}, s1_byte_q};
        end else if ((s1_byte_q & Lead2Mask) == Lead2Pat) begin
          gath_d = {{(CpW-ByteW){1'b0}}, s1_byte_q & Lead2Bits};
          pend_d = PendOne;
        end else if ((s1_byte_q & Lead3Mask) == Lead3Pat) begin
          gath_d = {{(CpW-ByteW){1'b0}}, s1_byte_q & Lead3Bits};
          pend_d = PendTwo;
        end else if ((s1_byte_q & Lead4Mask) == Lead4Pat) begin
          gath_d = {{(CpW-ByteW){1'b0}}, s1_byte_q & Lead4Bits};
          pend_d = PendThree;
        end
        // stray continuation or invalid lead: dropped
      end else if ((s1_byte_q & ContMask) == ContPat) begin
        pend_d = pend_q - PendOne;
        if (pend_q == PendOne) begin
          emit    = 1'b1;
          emit_cp = shifted;
          gath_d  = '0;
        end else begin
          gath_d = shifted;
        end
      end else begin
        // broken sequence: discard it and swallow the byte
        pend_d = PendNone;
        gath_d = '0;
      end
      if (s1_last_q) begin
        pend_d = PendNone;
        gath_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= PendNone;
      gath_q      <= '0;
    end else begin
      pend_q <= pend_d;
      gath_q <= gath_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && emit;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_string_i;
    end
    if (s1_adv && emit) begin
      out_cp_q   <= emit_cp;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = out_cp_q;
  assign ends_string_o = out_last_q;

endmodule
`default_nettype wire

@@ hw/rtl/utf8d_checker.sv @@
// port-level checker for the utf-8 decoder, bound to the top level
`default_nettype none
module utf8d_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic [utf8d_pkg::ByteW-1:0] data_byte_i,
  input wire logic                        end_of_string_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [utf8d_pkg::CpW-1:0]   code_point_o,
  input wire logic                        ends_string_o
);
  import utf8d_pkg::*;

  logic unused_inputs;
  assign unused_inputs = ^{data_byte_i, end_of_string_i};

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word withdrawn while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(code_point_o) && $stable(ends_string_o))
    else $error("result payload changed while stalled");

  // an empty result register never throttles the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // only one word is buffered behind a stalled result
  a_one_buffered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && in_valid_i && in_ready_o)
      ##1 (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted beyond the single buffered word");

endmodule

bind utf8_to_codepoint_decoder utf8d_checker u_utf8d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .data_byte_i     (data_byte_i),
  .end_of_string_i (end_of_string_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .code_point_o    (code_point_o),
  .ends_string_o   (ends_string_o)
);
`default_nettype wire

@@ bench/utf8_decoder_checker.sv @@
// checker for the utf-8 decoder: predicts code points from accepted bytes and compares
`timescale 1ns / 1ps
module utf8_decoder_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic [utf8d_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                        end_of_string_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic [utf8d_pkg::CpW-1:0]   code_point_i,
  input  wire logic                        ends_string_i,
  output int                               fail_count_o,
  output int                               awaiting_o
);
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } cp_word_t;

  cp_word_t         awaited_cps[$];
  cp_word_t         oldest;
  logic [PendW-1:0] conts_left;
  logic [CpW-1:0]   bits_so_far;

  initial begin
    fail_count_o = 0;
    awaiting_o   = 0;
  end

  // one byte through the predicted decoder; queues a code point when one completes
  task automatic decode_word(input logic [ByteW-1:0] b, input logic last);
    logic           emit;
    logic [CpW-1:0] cp;
    emit = 1'b0;
    cp   = '0;
    if (conts_left == PendNone) begin
      if (b <= AsciiMax) begin
        cp   = CpW'(b);
        emit = 1'b1;
      end else if ((b & Lead2Mask) == Lead2Pat) begin
        bits_so_far = CpW'(b & Lead2Bits);
        conts_left  = PendOne;
      end else if ((b & Lead3Mask) == Lead3Pat) begin
        bits_so_far = CpW'(b & Lead3Bits);
        conts_left  = PendTwo;
      end else if ((b & Lead4Mask) == Lead4Pat) begin
        bits_so_far = CpW'(b & Lead4Bits);
        conts_left  = PendThree;
      end
    end else if ((b & ContMask) == ContPat) begin
      bits_so_far = (bits_so_far << 6) | CpW'(b & ContBits);
      conts_left  = conts_left - PendOne;
      if (conts_left == PendNone) begin
        cp          = bits_so_far;
        emit        = 1'b1;
        bits_so_far = '0;
      end
    end else begin
      // sequence broken, the offending byte goes with it
      conts_left  = PendNone;
      bits_so_far = '0;
    end
    if (last) begin
      conts_left  = PendNone;
      bits_so_far = '0;
    end
    if (emit) awaited_cps.push_back('{cp: cp, last: last});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conts_left  = PendNone;
      bits_so_far = '0;
      awaited_cps.delete();
    end else begin
      // compare before predicting: a word taken now cannot come out at this edge
      if (out_valid_i && out_ready_i) begin
        if (awaited_cps.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected code point, expected none, got %h end %b",
                   $time, code_point_i, ends_string_i);
        end else begin
          oldest = awaited_cps.pop_front();
          if (code_point_i !== oldest.cp) begin
            fail_count_o++;
            $display("%0t: code point mismatch, expected %h, got %h",
                     $time, oldest.cp, code_point_i);
          end
          if (ends_string_i !== oldest.last) begin
            fail_count_o++;
            $display("%0t: end of string mismatch, expected %b, got %b",
                     $time, oldest.last, ends_string_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_word(data_byte_i, end_of_string_i);
    end
    awaiting_o = awaited_cps.size();
  end

endmodule

@@ bench/tb.sv @@
// top of the utf-8 decoder testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import utf8d_pkg::*;

  localparam int LimitCycles = 200000;
  localparam int HoldCycles  = 200;   // long receiver hold-off at the start
  localparam int DrainCycles = 20;    // quiet spell after the last code point has drained
  localparam int PhaseBytes  = 356;

  // sender idle and receiver stall percentages per random phase
  localparam int PhaseIdle  [4] = '{0, 58, 0, 31};
  localparam int PhaseStall [4] = '{0, 0, 58, 31};

  // directed bytes, bit 8 is the end-of-string flag
  localparam logic [8:0] Directed [27] = '{
    9'h000, 9'h07F,                  // ascii extremes
    9'h0C2, 9'h0A9,                  // two-byte sequence
    9'h0DF, 9'h0BF,                  // largest two-byte value
    9'h0E2, 9'h082, 9'h0AC,          // three-byte sequence
    9'h0F0, 9'h09F, 9'h098, 9'h080,  // four-byte sequence
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,  // all 21 bits set
    9'h080,                          // stray continuation, dropped
    9'h0F8, 9'h0FF,                  // invalid leads, dropped
    9'h0C3, 9'h041,                  // broken sequence eats the ascii byte
    9'h0E2, 9'h182,                  // string ends mid-sequence
    9'h141,                          // ascii word closing a string
    9'h0C2, 9'h1A9                   // sequence completed by the final word
  };

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic [ByteW-1:0] data_byte_i     = '0;
  logic             end_of_string_i = 1'b0;
  logic             out_ready_i     = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [CpW-1:0]   code_point_o;
  logic             ends_string_o;

  int fail_count;
  int awaiting;
  int cycles     = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = HoldCycles;
  int bytes_sent = 0;

  utf8_to_codepoint_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .ends_string_o  (ends_string_o)
  );

  utf8_decoder_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_i   (code_point_o),
    .ends_string_i  (ends_string_o),
    .fail_count_o   (fail_count),
    .awaiting_o     (awaiting)
  );

  always #5 clk_i = ~clk_i;

  // watchdog, well above the slowest legal run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: holds off for a long stretch first so the decoder backs up and
  // drops in_ready_o, then stalls at the rate of the current phase
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // rare end-of-string flag, lands on lead, middle and last bytes alike
  function automatic logic pick_eos();
    return $urandom_range(99) < 3;
  endfunction

  // lead byte of a sequence of len bytes with random payload bits
  function automatic logic [ByteW-1:0] lead_byte(input int len);
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    case (len)
      1:       return r & AsciiMax;
      2:       return Lead2Pat | (r & Lead2Bits);
      3:       return Lead3Pat | (r & Lead3Bits);
      default: return Lead4Pat | (r & Lead4Bits);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    return ContPat | (ByteW'($urandom) & ContBits);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_word(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // mostly well-formed characters, some cut short by a foreign byte, some noise
  task automatic send_random_char();
    int               kind;
    int               len;
    logic [ByteW-1:0] b;
    kind = $urandom_range(99);
    if (kind < 85) begin
      len = $urandom_range(1, 4);
      offer_word(lead_byte(len), pick_eos());
      repeat (len - 1) offer_word(cont_byte(), pick_eos());
    end else if (kind < 93) begin
      len = $urandom_range(2, 4);
      offer_word(lead_byte(len), pick_eos());
      repeat ($urandom_range(0, len - 2)) offer_word(cont_byte(), pick_eos());
      // anything but a continuation breaks the sequence
      b = ByteW'($urandom);
      if ((b & ContMask) == ContPat) b = b | ContMask;
      offer_word(b, pick_eos());
    end else begin
      offer_word(ByteW'($urandom), pick_eos());
    end
  endtask

  initial begin
    int phase;
    int target;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words are offered back to back while the receiver is still held off
    foreach (Directed[i]) offer_word(Directed[i][7:0], Directed[i][8]);

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = PhaseIdle[phase];
      stall_pct = PhaseStall[phase];
      target    = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_char();
    end
    in_valid_i <= 1'b0;

    // let the last code points drain, then a short quiet spell
    while (awaiting != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
